// ===== rtl/core/alwc_pkg.sv =====
package alwc_pkg;

    // Fixed field widths of the command and result ports
    localparam int FIELD_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int COUNT_W  = 7;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FIRST  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd4;

    // Completion status handed from the sequencer to the result stage
    typedef struct packed {
        logic valid;
        logic ok;
    } alwc_fin_t;

endpackage

// ===== rtl/core/array_list_with_cursor_core.sv =====
// Ordered list of up to CAPACITY entries with a read cursor.
// Command channel: opcode and data_in are taken at a rising edge where start
// is high and busy is low. Opcodes: clear, insert, first, next, remove.
// Result channel: done is high for exactly one cycle with ok, data_out and
// count; the receiver cannot stall, so each result beat is taken that cycle.
// Result and busy behaviour:
//   clear, insert, unused opcodes and any failing command: result in the cycle
//   after acceptance, busy stays low, a new command may follow at once.
//   first and next: entry read in the READ state, result registered after it,
//   busy high while in READ. remove: entry at the cursor read in READ, then
//   entries above it move down in SHIFT; the store reads one entry and writes
//   one entry per cycle to close the gap, and busy stays high until the result.
// Reset: list empty, cursor at zero, no result pending. Entry contents are not
// cleared; only entries below the count are ever read back.
module array_list_with_cursor_core
    import alwc_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic signed [FIELD_W-1:0]  data_in,
    output logic                       done,
    output logic                       ok,
    output logic signed [FIELD_W-1:0]  data_out,
    output logic [COUNT_W-1:0]         count
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    logic signed [EXT_W-1:0] din_ext;
    logic [EXT_W-1:0]        dout_ext;
    logic [DATA_WIDTH-1:0]   wr_value;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [DATA_WIDTH-1:0]   mem_rdata;

    alwc_fin_t               fin;
    logic [DATA_WIDTH-1:0]   fin_data;
    logic [CNT_W-1:0]        fin_count;

    logic                    done_reg;
    logic                    ok_reg;
    logic [FIELD_W-1:0]      data_out_reg, data_out_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    // Fit the command value to the entry width
    assign din_ext  = EXT_W'(data_in);
    assign wr_value = din_ext[DATA_WIDTH-1:0];

    alwc_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (CAPACITY),
        .AW         (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    alwc_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .CAPACITY   (CAPACITY),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .wr_value  (wr_value),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .fin       (fin),
        .fin_data  (fin_data),
        .fin_count (fin_count)
    );

    // Fit the returned entry and count to the result fields
    assign dout_ext      = EXT_W'(fin_data);
    assign data_out_next = dout_ext[FIELD_W-1:0];
    assign count_next    = COUNT_W'(fin_count);

    // Result beat strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
            ok_reg   <= fin.valid & fin.ok;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            data_out_reg <= data_out_next;
            count_reg    <= count_next;
        end
    end

    assign done     = done_reg;
    assign ok       = ok_reg;
    assign data_out = signed'(data_out_reg);
    assign count    = count_reg;

    // A result beat only leaves once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // Single-cycle commands answer on the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode != OP_FIRST && opcode != OP_NEXT && opcode != OP_REMOVE)
        |=> done)
        else $error("single-cycle command gave no result");

    // Clear always succeeds and empties the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_CLEAR) |=> (done && ok && count == '0))
        else $error("clear did not empty the list");

    // A failed command returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (data_out == '0))
        else $error("failed command returned data");

endmodule

// ===== rtl/core/alwc_store.sv =====
module alwc_store
    import alwc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64,
    parameter int AW         = 6
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, every cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/alwc_ctrl.sv =====
module alwc_ctrl
    import alwc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 64,
    parameter int AW         = 6,
    parameter int CNT_W      = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [OPCODE_W-1:0]       opcode,
    input  logic [DATA_WIDTH-1:0]     wr_value,
    output logic                      busy,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [DATA_WIDTH-1:0]     mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  logic [DATA_WIDTH-1:0]     mem_rdata,
    output alwc_fin_t                 fin,
    output logic [DATA_WIDTH-1:0]     fin_data,
    output logic [CNT_W-1:0]          fin_count
);

    localparam int CW = CNT_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  remove_reg, remove_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic signed [CW-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;

    logic signed [CW-1:0]  cnt_s;
    logic signed [CW-1:0]  cur_inc;
    logic signed [CW-1:0]  cur_dec;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      idx_plus2;

    assign cnt_s     = signed'({1'b0, count_reg});
    assign cur_inc   = cursor_reg + $signed(CW'(1));
    assign cur_dec   = cursor_reg - $signed(CW'(1));
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_plus2 = idx_reg + CNT_W'(2);

    assign busy      = (state_reg != ST_IDLE);
    assign fin_count = count_next;

    // Sequencer: decode a command; for remove, walk the store one entry per cycle
    always_comb
    begin
        state_next  = state_reg;
        remove_next = remove_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = wr_value;
        mem_raddr   = cursor_reg[AW-1:0];
        fin         = '{valid: 1'b0, ok: 1'b0};
        fin_data    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                            fin         = '{valid: 1'b1, ok: 1'b1};
                        end
                        OP_INSERT:
                        begin
                            if (count_reg != CNT_W'(CAPACITY))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                fin        = '{valid: 1'b1, ok: 1'b1};
                            end
                            else
                            begin
                                fin = '{valid: 1'b1, ok: 1'b0};
                            end
                        end
                        OP_FIRST:
                        begin
                            mem_raddr = '0;
                            if (count_reg != '0)
                            begin
                                cursor_next = '0;
                                remove_next = 1'b0;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                fin = '{valid: 1'b1, ok: 1'b0};
                            end
                        end
                        OP_NEXT:
                        begin
                            mem_raddr = cur_inc[AW-1:0];
                            if (cur_inc < cnt_s)
                            begin
                                cursor_next = cur_inc;
                                remove_next = 1'b0;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                fin = '{valid: 1'b1, ok: 1'b0};
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!cursor_reg[CW-1] && (cursor_reg < cnt_s))
                            begin
                                remove_next = 1'b1;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                fin = '{valid: 1'b1, ok: 1'b0};
                            end
                        end
                        default:
                        begin
                            fin = '{valid: 1'b1, ok: 1'b0};
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (!remove_reg)
                begin
                    fin        = '{valid: 1'b1, ok: 1'b1};
                    fin_data   = mem_rdata;
                    state_next = ST_IDLE;
                end
                else if (cur_inc == cnt_s)
                begin
                    // Last entry removed: nothing to close up
                    fin         = '{valid: 1'b1, ok: 1'b1};
                    fin_data    = mem_rdata;
                    count_next  = cnt_dec;
                    cursor_next = cur_dec;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    hold_next  = mem_rdata;
                    mem_raddr  = cur_inc[AW-1:0];
                    idx_next   = cursor_reg[CNT_W-1:0];
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Move the entry above down into the gap
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (idx_inc == cnt_dec)
                begin
                    fin         = '{valid: 1'b1, ok: 1'b1};
                    fin_data    = hold_reg;
                    count_next  = cnt_dec;
                    cursor_next = cur_dec;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    mem_raddr = idx_plus2[AW-1:0];
                    idx_next  = idx_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remove_reg <= 1'b0;
            count_reg  <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remove_reg <= remove_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload hold, no reset
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule
